### design/psph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package psph_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int ANGLE_BINS   = 256;
   localparam int RANGE_BINS   = 128;
   localparam int COUNT_BITS   = 16;

   localparam int CH_BITS    = 2;
   localparam int ANG_BITS   = 8;
   localparam int RNG_BITS   = 7;
   localparam int ADDR_BITS  = CH_BITS + ANG_BITS + RNG_BITS;
   localparam int BIN_TOTAL  = NUM_CHANNELS * ANGLE_BINS * RANGE_BINS;
   localparam int MAP_DEPTH  = 256;
   localparam int MAP_BITS   = 3;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS    = 4;
   localparam int CW           = 36;
   localparam int ZW           = 20;
   localparam logic signed [ZW-1:0] PI_Q16 = 20'sd205887;
   localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_BIN   = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [1:0] CSR_RANGE_RES  = 2'd0;
   localparam logic [1:0] CSR_ANGLE_RES  = 2'd1;
   localparam logic [1:0] CSR_FILTER_ON  = 2'd2;
   localparam logic [1:0] CSR_NORMAL_LIM = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_CORDIC, ST_MAG, ST_RIDX, ST_AMAG, ST_AIDX,
      ST_CHECK, ST_MAPRD, ST_BINRD, ST_BINWAIT, ST_BINWR, ST_READRD, ST_READWAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } cordic_ctrl_type;

   function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_BITS-1:0] i);
      logic signed [ZW-1:0] v;
      unique case (i)
         4'd0: v = 20'sd51472;
         4'd1: v = 20'sd30386;
         4'd2: v = 20'sd16055;
         4'd3: v = 20'sd8150;
         4'd4: v = 20'sd4091;
         4'd5: v = 20'sd2047;
         4'd6: v = 20'sd1024;
         4'd7: v = 20'sd512;
         4'd8: v = 20'sd256;
         4'd9: v = 20'sd128;
         4'd10: v = 20'sd64;
         4'd11: v = 20'sd32;
         4'd12: v = 20'sd16;
         4'd13: v = 20'sd8;
         4'd14: v = 20'sd4;
         default: v = 20'sd2;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### design/polar_semantic_point_histogram_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Polar semantic point histogram.
// Commands enter on req_*: a beat is taken when start is high and busy is low.
// Mode 0 clears every bin, mode 1 loads one class-map entry, mode 2 bins one
// point, mode 3 reads one bin. Each command gives exactly one result beat on
// rsp_*, marked by rsp_valid for one cycle; the receiver cannot stall.
// A binned point passes through 16 CORDIC iterations on one shared add/shift
// unit, then the scale multiplies one per cycle, the class-map read and the
// bin read-modify-write. A point at the origin skips all of these; a point
// dropped by the bounds or normal check ends before the class-map read, and
// one dropped by the class map ends before the bin read. A clear sweeps the
// histogram memory one entry per cycle. A new command can be taken in the
// cycle of the result beat; while a command is in progress busy stays high.
// After reset the block runs a clearing pass over all 131072 histogram
// entries and, concurrently, over all 256 class-map entries with busy high;
// configuration writes on csr_* are taken at any time and apply at once.
// Registers: 0 range bins per metre, 1 angle bins per radian, 2 normal filter
// enable, 3 normal z limit.
module polar_semantic_point_histogram_core import psph_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [23:0] req_x_pos,
   input  wire logic signed [23:0] req_y_pos,
   input  wire logic [7:0]         req_point_class,
   input  wire logic signed [15:0] req_normal_z,
   input  wire logic [2:0]         req_map_entry,
   input  wire logic [1:0]         req_read_channel,
   input  wire logic [7:0]         req_read_angle,
   input  wire logic [6:0]         req_read_range,
   output logic                    rsp_valid,
   output logic [15:0]             rsp_bin_count,
   output logic                    rsp_point_binned,
   output logic                    rsp_bin_saturated,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   state_type state_ff, state_in;
   logic [15:0] range_res_ff, angle_res_ff;
   logic filter_on_ff;
   logic signed [15:0] limit_ff;

   logic [1:0]  mode_ff;
   logic signed [23:0] x_ff, y_ff;
   logic [7:0]  cls_ff;
   logic signed [15:0] nz_ff;
   logic [2:0]  ment_ff;
   logic [ADDR_BITS-1:0] raddr_ff, raddr_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic map_clr_ff, map_clr_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [63:0] prod_ff, prod_in;
   logic [RNG_BITS-1:0] ridx_ff, ridx_in;
   logic ridx_ok_ff, ridx_ok_in;
   logic [ANG_BITS-1:0] aidx_ff, aidx_in;
   logic aidx_ok_ff, aidx_ok_in;
   logic zneg_ff, zneg_in;
   logic [15:0] cnt_ff, cnt_in;
   logic bin_ff, bin_in, sat_ff, sat_in, vld_ff, vld_in;

   cordic_ctrl_type cctl;
   logic signed [CW-1:0] c_a;
   logic signed [ZW-1:0] c_z;

   logic h_we, m_we;
   logic [ADDR_BITS-1:0] h_waddr, h_raddr;
   logic [COUNT_BITS-1:0] h_wdata, h_rdata;
   logic [7:0] m_waddr;
   logic [MAP_BITS-1:0] m_wdata, m_rdata;

   logic [CW-1:0] mul_a;
   logic [15:0] mul_b;
   logic [63:0] mul_p;
   logic [CW-1:0] a_pos;
   logic [ZW-1:0] zabs;
   logic [39:0] ang_mag;
   logic signed [ANG_BITS+1:0] t_ind;
   logic accept;

   assign accept = start && !busy;

   psph_cordic u_cordic (
      .clock(clock), .ctrl(cctl), .x_pos(x_ff), .y_pos(y_ff),
      .step_idx(step_ff), .a_out(c_a), .z_out(c_z)
   );

   psph_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_TOTAL)) u_hist (
      .clock(clock), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
      .rd_addr(h_raddr), .rd_data(h_rdata)
   );

   psph_ram #(.WIDTH(MAP_BITS), .DEPTH(MAP_DEPTH)) u_map (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_addr(cls_ff), .rd_data(m_rdata)
   );

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         range_res_ff <= 16'd256;
         angle_res_ff <= 16'd20861;
         filter_on_ff <= 1'b0;
         limit_ff     <= 16'sd14746;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RANGE_RES:  range_res_ff <= csr_data;
            CSR_ANGLE_RES:  angle_res_ff <= csr_data;
            CSR_FILTER_ON:  filter_on_ff <= csr_data[0];
            CSR_NORMAL_LIM: limit_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         map_clr_ff <= 1'b1;
         vld_ff     <= 1'b0;
         mode_ff    <= MODE_READ;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         map_clr_ff <= map_clr_in;
         vld_ff     <= vld_in;
         if (accept) begin
            mode_ff <= req_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_x_pos;
         y_ff    <= req_y_pos;
         cls_ff  <= req_point_class;
         nz_ff   <= req_normal_z;
         ment_ff <= req_map_entry;
      end
      raddr_ff   <= raddr_in;
      step_ff    <= step_in;
      prod_ff    <= prod_in;
      ridx_ff    <= ridx_in;
      ridx_ok_ff <= ridx_ok_in;
      aidx_ff    <= aidx_in;
      aidx_ok_ff <= aidx_ok_in;
      zneg_ff    <= zneg_in;
      cnt_ff     <= cnt_in;
      bin_ff     <= bin_in;
      sat_ff     <= sat_in;
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      map_clr_in = map_clr_ff;
      raddr_in   = raddr_ff;
      step_in    = step_ff;
      prod_in    = prod_ff;
      ridx_in    = ridx_ff;
      ridx_ok_in = ridx_ok_ff;
      aidx_in    = aidx_ff;
      aidx_ok_in = aidx_ok_ff;
      zneg_in    = zneg_ff;
      cnt_in     = cnt_ff;
      bin_in     = bin_ff;
      sat_in     = sat_ff;
      vld_in     = 1'b0;
      cctl       = '0;
      h_we       = 1'b0;
      h_waddr    = raddr_ff;
      h_wdata    = '0;
      h_raddr    = raddr_ff;
      m_we       = 1'b0;
      m_waddr    = cls_ff;
      m_wdata    = ment_ff;
      mul_a      = '0;
      mul_b      = '0;
      a_pos      = c_a[CW-1] ? '0 : CW'(c_a);
      zabs       = c_z[ZW-1] ? ZW'(-c_z) : ZW'(c_z);
      ang_mag    = 40'((prod_ff + 64'(1 << 23)) >> 24);
      t_ind      = zneg_ff ? -($signed({1'b0, ang_mag[ANG_BITS:0]}))
                           : $signed({1'b0, ang_mag[ANG_BITS:0]});
      t_ind      = t_ind + (ANG_BITS+2)'(ANGLE_BINS / 2);
      busy       = (state_ff != ST_IDLE);

      if (map_clr_ff) begin
         m_we    = 1'b1;
         m_waddr = clr_ff[7:0];
         m_wdata = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in = '0;
               bin_in = 1'b0;
               sat_in = 1'b0;
               unique case (req_mode)
                  MODE_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  MODE_LOAD: state_in = ST_DONE;
                  MODE_BIN: begin
                     step_in  = '0;
                     state_in = ST_CORDIC;
                  end
                  default: begin
                     raddr_in = {req_read_channel, req_read_angle, req_read_range};
                     state_in = ST_READRD;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            h_we    = 1'b1;
            h_waddr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff[7:0] == 8'hff) begin
               map_clr_in = 1'b0;
            end
            if (clr_ff == ADDR_BITS'(BIN_TOTAL - 1)) begin
               state_in = mode_ff == MODE_CLEAR && !map_clr_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_CORDIC: begin
            if (x_ff == '0 && y_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cctl.start = 1'b1;
               state_in   = ST_MAG;
               zneg_in    = 1'b1;
            end
         end
         ST_MAG: begin
            if (zneg_ff) begin
               cctl.step = 1'b1;
               step_in   = step_ff + 1'b1;
               if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
                  zneg_in = 1'b0;
               end
            end else begin
               mul_a    = a_pos;
               mul_b    = INV_GAIN_Q16;
               prod_in  = mul_p >> 16;
               state_in = ST_RIDX;
            end
         end
         ST_RIDX: begin
            mul_a    = prod_ff[CW-1:0];
            mul_b    = range_res_ff;
            prod_in  = (mul_p + 64'(1 << 23)) >> 24;
            state_in = ST_AMAG;
         end
         ST_AMAG: begin
            ridx_in    = prod_ff[RNG_BITS-1:0];
            ridx_ok_in = (prod_ff < 64'(RANGE_BINS));
            mul_a      = CW'(zabs);
            mul_b      = angle_res_ff;
            prod_in    = mul_p;
            zneg_in    = c_z[ZW-1];
            state_in   = ST_AIDX;
         end
         ST_AIDX: begin
            aidx_in    = t_ind[ANG_BITS-1:0];
            aidx_ok_in = ang_mag[39:ANG_BITS+1] == '0 && t_ind >= 0
                         && t_ind < (ANG_BITS+2)'(ANGLE_BINS);
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            if (!(aidx_ok_ff && ridx_ok_ff) || (filter_on_ff && nz_ff >= limit_ff)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MAPRD;
            end
         end
         ST_MAPRD: begin
            state_in = ST_BINRD;
         end
         ST_BINRD: begin
            if (m_rdata == '0 || m_rdata > MAP_BITS'(NUM_CHANNELS)) begin
               state_in = ST_DONE;
            end else begin
               raddr_in = {CH_BITS'(m_rdata - 1'b1), aidx_ff, ridx_ff};
               state_in = ST_BINWAIT;
            end
         end
         ST_BINWAIT: begin
            state_in = ST_BINWR;
         end
         ST_BINWR: begin
            bin_in = 1'b1;
            if (h_rdata == '1) begin
               sat_in = 1'b1;
            end else begin
               h_we    = 1'b1;
               h_wdata = h_rdata + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_READRD: begin
            state_in = ST_READWAIT;
         end
         ST_READWAIT: begin
            cnt_in   = h_rdata;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (mode_ff == MODE_LOAD && !map_clr_ff) begin
               m_we    = 1'b1;
               m_waddr = cls_ff;
               m_wdata = ment_ff;
            end
            vld_in   = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid         = vld_ff;
   assign rsp_bin_count     = cnt_ff;
   assign rsp_point_binned  = bin_ff;
   assign rsp_bin_saturated = sat_ff;

`ifndef SYNTHESIS
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat longer than one cycle");
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy not raised after accept");
   a_flags_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && mode_ff != MODE_BIN) |-> (!rsp_point_binned && !rsp_bin_saturated))
      else $error("bin flags outside bin mode");
   a_sat_binned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bin_saturated) |-> rsp_point_binned)
      else $error("saturated without binned");
`endif

endmodule
`default_nettype wire

### design/psph_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module psph_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### design/psph_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module psph_cordic import psph_pkg::*; (
   input  wire logic                    clock,
   input  wire cordic_ctrl_type         ctrl,
   input  wire logic signed [23:0]      x_pos,
   input  wire logic signed [23:0]      y_pos,
   input  wire logic [STEP_BITS-1:0]    step_idx,
   output logic signed [CW-1:0]         a_out,
   output logic signed [ZW-1:0]         z_out
);

   logic signed [CW-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [CW-1:0] a0, b0, da, db;

   always_comb begin
      a0 = CW'(y_pos) <<< 8;
      b0 = CW'(x_pos) <<< 8;
      a_in = a_ff;
      b_in = b_ff;
      z_in = z_ff;
      da = b_ff >>> step_idx;
      db = a_ff >>> step_idx;
      if (ctrl.start) begin
         if (y_pos < 0) begin
            a_in = -a0;
            b_in = -b0;
            z_in = (x_pos >= 0) ? PI_Q16 : -PI_Q16;
         end else begin
            a_in = a0;
            b_in = b0;
            z_in = '0;
         end
      end else if (ctrl.step) begin
         if (b_ff >= 0) begin
            a_in = a_ff + da;
            b_in = b_ff - db;
            z_in = z_ff + atan_q16(step_idx);
         end else begin
            a_in = a_ff - da;
            b_in = b_ff + db;
            z_in = z_ff - atan_q16(step_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      z_ff <= z_in;
   end

   assign a_out = a_ff;
   assign z_out = z_ff;

endmodule
`default_nettype wire

### tb/polar_semantic_point_histogram_checker.sv
`timescale 1ns / 1ps
module polar_semantic_point_histogram_checker import psph_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic signed [23:0] req_x_pos,
   input  wire logic signed [23:0] req_y_pos,
   input  wire logic [7:0]         req_point_class,
   input  wire logic signed [15:0] req_normal_z,
   input  wire logic [2:0]         req_map_entry,
   input  wire logic [1:0]         req_read_channel,
   input  wire logic [7:0]         req_read_angle,
   input  wire logic [6:0]         req_read_range,
   input  wire logic               rsp_valid,
   input  wire logic [15:0]        rsp_bin_count,
   input  wire logic               rsp_point_binned,
   input  wire logic               rsp_bin_saturated,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data,
   output int                      errors,
   output int                      outstanding
);

   typedef struct packed {
      logic [15:0] count;
      logic        binned;
      logic        saturated;
   } bin_result_type;

   localparam longint HALF_TURN_Q16 = 205887;
   localparam longint RECIP_GAIN_Q16 = 39797;
   localparam longint ARCTAN_Q16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                          256, 128, 64, 32, 16, 8, 4, 2};

   logic [15:0] range_scale;
   logic [15:0] angle_scale;
   logic        filter_on;
   logic signed [15:0] z_limit;
   logic [15:0] bin_counts [0:BIN_TOTAL-1];
   logic [2:0]  channel_map [0:MAP_DEPTH-1];
   bin_result_type pending_results [$];

   function automatic bin_result_type histogram_update(input logic [1:0] mode,
         input logic signed [23:0] x, input logic signed [23:0] y, input logic [7:0] cls,
         input logic signed [15:0] nz, input logic [2:0] entry, input logic [1:0] ch,
         input logic [7:0] an, input logic [6:0] rg);
      bin_result_type res;
      longint a, b, z, da, db, t_ind;
      longint unsigned m, r_ind, amag;
      logic [2:0] e;
      int unsigned idx;
      res = '0;
      case (mode)
         MODE_CLEAR: begin
            foreach (bin_counts[k]) bin_counts[k] = '0;
         end
         MODE_LOAD: begin
            channel_map[cls] = entry;
         end
         MODE_READ: begin
            res.count = bin_counts[{ch, an, rg}];
         end
         default: begin
            if (x != 0 || y != 0) begin
               a = longint'(y) * 256;
               b = longint'(x) * 256;
               z = 0;
               if (a < 0) begin
                  z = (b >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
                  a = -a;
                  b = -b;
               end
               for (int i = 0; i < 16; i++) begin
                  da = b >>> i;
                  db = a >>> i;
                  if (b >= 0) begin
                     a += da; b -= db; z += ARCTAN_Q16[i];
                  end else begin
                     a -= da; b += db; z -= ARCTAN_Q16[i];
                  end
               end
               if (a < 0) a = 0;
               m = (longint'(a) * RECIP_GAIN_Q16) >> 16;
               r_ind = (m * range_scale + (64'd1 << 23)) >> 24;
               amag = longint'(z < 0 ? -z : z) * angle_scale;
               amag = (amag + (64'd1 << 23)) >> 24;
               t_ind = (z < 0 ? -longint'(amag) : longint'(amag)) + ANGLE_BINS / 2;
               if (t_ind >= 0 && t_ind < ANGLE_BINS && r_ind < RANGE_BINS &&
                   !(filter_on && nz >= z_limit)) begin
                  e = channel_map[cls];
                  if (e != 0 && (e - 1) < NUM_CHANNELS) begin
                     idx = ((e - 1) * ANGLE_BINS + int'(t_ind)) * RANGE_BINS + int'(r_ind);
                     res.binned = 1'b1;
                     if (bin_counts[idx] == 16'hffff) res.saturated = 1'b1;
                     else bin_counts[idx] = bin_counts[idx] + 1'b1;
                  end
               end
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      bin_result_type got, want;
      if (reset) begin
         range_scale = 16'd256;
         angle_scale = 16'd20861;
         filter_on = 1'b0;
         z_limit = 16'sd14746;
         foreach (bin_counts[k]) bin_counts[k] = '0;
         foreach (channel_map[k]) channel_map[k] = '0;
         pending_results.delete();
         errors <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_RANGE_RES: range_scale = csr_data;
               CSR_ANGLE_RES: angle_scale = csr_data;
               CSR_FILTER_ON: filter_on = csr_data[0];
               default:       z_limit = csr_data;
            endcase
         end
         if (rsp_valid) begin
            got = '{rsp_bin_count, rsp_point_binned, rsp_bin_saturated};
            if (pending_results.size() == 0) begin
               if (errors < 10) $display("checker: result beat with nothing expected");
               errors <= errors + 1;
            end else begin
               want = pending_results.pop_front();
               if (got != want) begin
                  if (errors < 10)
                     $display("checker: mismatch count %0d/%0d binned %0d/%0d sat %0d/%0d",
                              want.count, got.count, want.binned, got.binned,
                              want.saturated, got.saturated);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy)
            pending_results.push_back(histogram_update(req_mode, req_x_pos, req_y_pos,
               req_point_class, req_normal_z, req_map_entry, req_read_channel,
               req_read_angle, req_read_range));
      end
      outstanding <= pending_results.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import psph_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_mode;
   logic signed [23:0] req_x_pos;
   logic signed [23:0] req_y_pos;
   logic [7:0]         req_point_class;
   logic signed [15:0] req_normal_z;
   logic [2:0]         req_map_entry;
   logic [1:0]         req_read_channel;
   logic [7:0]         req_read_angle;
   logic [6:0]         req_read_range;
   logic               rsp_valid;
   logic [15:0]        rsp_bin_count;
   logic               rsp_point_binned;
   logic               rsp_bin_saturated;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;
   int                 errors;
   int                 outstanding;
   bit                 gaps_on;
   int                 item_count;

   always #5 clock = ~clock;

   polar_semantic_point_histogram_core dut (.*);
   polar_semantic_point_histogram_checker checker_i (.*);

   task automatic send_command(input logic [1:0] m, input logic signed [23:0] x,
         input logic signed [23:0] y, input logic [7:0] cls, input logic signed [15:0] nz,
         input logic [2:0] entry, input logic [1:0] ch, input logic [7:0] an,
         input logic [6:0] rg);
      start <= 1'b1;
      req_mode <= m;
      req_x_pos <= x;
      req_y_pos <= y;
      req_point_class <= cls;
      req_normal_z <= nz;
      req_map_entry <= entry;
      req_read_channel <= ch;
      req_read_angle <= an;
      req_read_range <= rg;
      do @(negedge clock); while (busy);
      @(posedge clock);
      item_count++;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   task automatic bin_point(input logic signed [23:0] x, input logic signed [23:0] y,
         input logic [7:0] cls, input logic signed [15:0] nz);
      send_command(MODE_BIN, x, y, cls, nz, 3'($urandom), 2'($urandom), 8'($urandom),
                   7'($urandom));
   endtask

   task automatic read_bin(input logic [1:0] ch, input logic [7:0] an, input logic [6:0] rg);
      send_command(MODE_READ, 24'($urandom), 24'($urandom), 8'($urandom), 16'($urandom),
                   3'($urandom), ch, an, rg);
   endtask

   task automatic load_map(input logic [7:0] cls, input logic [2:0] entry);
      send_command(MODE_LOAD, 24'($urandom), 24'($urandom), cls, 16'($urandom), entry,
                   2'($urandom), 8'($urandom), 7'($urandom));
   endtask

   function automatic logic signed [23:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 24'($urandom);
         2, 3:    return $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
         default: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      endcase
   endfunction

   task automatic random_phase(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         if (item_count > 420) gaps_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 10)
            load_map($urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)),
                     $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(0, 4)));
         else if (pick < 70)
            bin_point(pick_coord(), pick_coord(),
                      $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)),
                      $signed(16'($urandom_range(0, 32768))) - 16'sd16384);
         else if ($urandom_range(0, 2) != 0)
            read_bin(2'($urandom), 8'(125 + $urandom_range(0, 6)),
                     7'($urandom_range(0, 3)));
         else
            read_bin(2'($urandom), 8'($urandom), 7'($urandom));
      end
   endtask

   task automatic set_regs(input logic [15:0] rr, input logic [15:0] ar, input logic f,
         input logic signed [15:0] lim);
      drain();
      write_reg(CSR_RANGE_RES, rr);
      write_reg(CSR_ANGLE_RES, ar);
      write_reg(CSR_FILTER_ON, {15'd0, f});
      write_reg(CSR_NORMAL_LIM, lim);
      csr_write <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_READ;
      req_x_pos = '0;
      req_y_pos = '0;
      req_point_class = '0;
      req_normal_z = '0;
      req_map_entry = '0;
      req_read_channel = '0;
      req_read_angle = '0;
      req_read_range = '0;
      csr_write = 1'b0;
      csr_index = CSR_RANGE_RES;
      csr_data = '0;
      gaps_on = 1'b1;
      item_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      load_map(8'd1, 3'd1);
      load_map(8'd2, 3'd4);
      load_map(8'd3, 3'd7);
      load_map(8'd255, 3'd2);
      bin_point(24'sd256, 24'sd256, 8'd1, 16'sd0);
      bin_point(24'sd256, 24'sd256, 8'd1, 16'sd0);
      bin_point(24'sd0, 24'sd0, 8'd1, 16'sd0);
      bin_point(-24'sd256, -24'sd256, 8'd1, 16'sd0);
      bin_point(24'sd0, -24'sd256, 8'd1, 16'sd0);
      bin_point(-24'sd256, 24'sd1024, 8'd2, -16'sd16384);
      bin_point(24'sh7fffff, 24'sh7fffff, 8'd1, 16'sd0);
      bin_point(-24'sh800000, -24'sh800000, 8'd1, 16'sd0);
      bin_point(24'sd256, 24'sd512, 8'd9, 16'sd0);
      bin_point(24'sd256, 24'sd512, 8'd3, 16'sd0);
      bin_point(24'sd512, 24'sd2560, 8'd255, 16'sd16384);
      read_bin(2'd0, 8'd192, 7'd1);
      read_bin(2'd3, 8'd255, 7'd127);
      read_bin(2'd3, 8'd0, 7'd0);
      set_regs(16'd256, 16'd20861, 1'b1, 16'sd0);
      bin_point(24'sd256, 24'sd256, 8'd1, -16'sd16384);
      bin_point(24'sd256, 24'sd256, 8'd1, 16'sd0);
      bin_point(24'sd256, 24'sd256, 8'd1, 16'sd16384);
      read_bin(2'd0, 8'd192, 7'd1);
      send_command(MODE_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
      read_bin(2'd0, 8'd192, 7'd1);

      set_regs(16'd256, 16'd20861, 1'b0, 16'sd14746);
      random_phase(100);
      set_regs(16'd64, 16'd256, 1'b1, 16'sd0);
      random_phase(120);
      set_regs(16'hffff, 16'hffff, 1'b1, -16'sd16384);
      random_phase(60);
      drain();
      send_command(MODE_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0);
      set_regs(16'd1, 16'd1, 1'b0, 16'sd16384);
      random_phase(60);
      set_regs(16'd0, 16'd0, 1'b1, 16'sd16384);
      random_phase(40);
      set_regs(16'd128, 16'd512, 1'b0, 16'sd8192);
      random_phase(70);
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && outstanding == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

### files.f
design/psph_pkg.sv
design/psph_ram.sv
design/psph_cordic.sv
design/polar_semantic_point_histogram_core.sv
tb/polar_semantic_point_histogram_checker.sv
tb/tb_top.sv
